// File: hdl/sflbf_pkg.sv
// Shared types, constants and codes for the best-fit free-region table.
`timescale 1ns / 1ps
package sflbf_pkg;

  localparam int OFF_W  = 40;
  localparam int SIZE_W = 24;
  localparam int ID_W   = 31;
  localparam int NB_W   = 41;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 3;
  localparam int IN_W   = 96;
  localparam int OUT_W  = 184;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_POPPED   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOFIT    = 3'd4;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic            load;
    logic            scan_rd;
    logic            scan_chk;
    logic            decide;
    logic            up_rd;
    logic            up_wr;
    logic            dn_rd;
    logic            dn_wr;
    logic            put_new;
    logic            dec;
    logic            set_st;
    logic [ST_W-1:0] st;
    logic            emit;
  } cmd_t;

  typedef struct packed {
    logic op_pop;
    logic idx_eq_count;
    logic idx_eq_pos;
    logic dn_last;
    logic full;
    logic dup;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/sflbf_ctrl.sv
// Controller state machine sequencing the scan and shift passes.
`timescale 1ns / 1ps
module sflbf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sflbf_pkg::sts_t sts,
  output sflbf_pkg::cmd_t cmd
);

  sflbf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sflbf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sflbf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sflbf_pkg::S_SCAN_RD;
        end
      end
      sflbf_pkg::S_SCAN_RD: begin
        if (sts.idx_eq_count) begin
          state_next = sflbf_pkg::S_DECIDE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = sflbf_pkg::S_SCAN_CHK;
        end
      end
      sflbf_pkg::S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = sflbf_pkg::S_SCAN_RD;
      end
      sflbf_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.set_st = 1'b1;
        if (sts.op_pop) begin
          if (sts.found) begin
            cmd.st     = sflbf_pkg::ST_POPPED;
            state_next = sflbf_pkg::S_DN_RD;
          end else begin
            cmd.st     = sflbf_pkg::ST_NOFIT;
            state_next = sflbf_pkg::S_DONE;
          end
        end else if (sts.dup) begin
          cmd.st     = sflbf_pkg::ST_DUP;
          state_next = sflbf_pkg::S_DONE;
        end else if (sts.full) begin
          cmd.st     = sflbf_pkg::ST_FULL;
          state_next = sflbf_pkg::S_DONE;
        end else begin
          cmd.st     = sflbf_pkg::ST_INSERTED;
          state_next = sflbf_pkg::S_UP_RD;
        end
      end
      sflbf_pkg::S_UP_RD: begin
        if (sts.idx_eq_pos) begin
          cmd.put_new = 1'b1;
          state_next  = sflbf_pkg::S_DONE;
        end else begin
          cmd.up_rd  = 1'b1;
          state_next = sflbf_pkg::S_UP_WR;
        end
      end
      sflbf_pkg::S_UP_WR: begin
        cmd.up_wr  = 1'b1;
        state_next = sflbf_pkg::S_UP_RD;
      end
      sflbf_pkg::S_DN_RD: begin
        if (sts.dn_last) begin
          cmd.dec    = 1'b1;
          state_next = sflbf_pkg::S_DONE;
        end else begin
          cmd.dn_rd  = 1'b1;
          state_next = sflbf_pkg::S_DN_WR;
        end
      end
      sflbf_pkg::S_DN_WR: begin
        cmd.dn_wr  = 1'b1;
        state_next = sflbf_pkg::S_DN_RD;
      end
      sflbf_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sflbf_pkg::S_IDLE;
        end
      end
      default: state_next = sflbf_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hdl/sflbf_dp.sv
// Datapath: entry memory, scan registers, entry count and output register.
`timescale 1ns / 1ps
module sflbf_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sflbf_pkg::cmd_t                cmd,
  output sflbf_pkg::sts_t                sts,
  input  logic                           in_action,
  input  logic [sflbf_pkg::IN_W-1:0]     in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sflbf_pkg::ST_W-1:0]     out_status,
  output logic [sflbf_pkg::OUT_W-1:0]    out_data,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  sflbf_pkg::entry_t mem [TABLE_DEPTH];
  sflbf_pkg::entry_t rdata, hit, fresh;
  logic [AW-1:0] raddr;
  logic [CW-1:0] idx, pos;
  logic          op, found, dup, next_got;
  logic [sflbf_pkg::NB_W-1:0] prev_off, next_off;
  logic [sflbf_pkg::ST_W-1:0] res_st;
  logic [CW:0]   idx_inc;

  assign idx_inc = {1'b0, idx} + 1'b1;

  always_comb begin
    if (cmd.up_rd) begin
      raddr = AW'(idx - 1'b1);
    end else if (cmd.dn_rd) begin
      raddr = AW'(idx_inc);
    end else begin
      raddr = AW'(idx);
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.up_wr || cmd.dn_wr) begin
      mem[AW'(idx)] <= rdata;
    end else if (cmd.put_new) begin
      mem[AW'(pos)] <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= in_action;
      fresh    <= {in_data[39:0], in_data[63:40], in_data[94:64]};
      idx      <= '0;
      found    <= 1'b0;
      dup      <= 1'b0;
      next_got <= 1'b0;
      prev_off <= '1;
      next_off <= '1;
      hit      <= '0;
    end
    if (cmd.scan_chk) begin
      idx <= CW'(idx_inc);
      if (op == sflbf_pkg::ACT_INSERT) begin
        if (rdata.off == fresh.off) begin
          dup <= 1'b1;
        end
        if (!found && rdata.size > fresh.size) begin
          found <= 1'b1;
          pos   <= idx;
        end
      end else if (!found) begin
        if (rdata.size >= fresh.size) begin
          found <= 1'b1;
          pos   <= idx;
          hit   <= rdata;
        end else begin
          prev_off <= {1'b0, rdata.off};
        end
      end else if (!next_got) begin
        next_got <= 1'b1;
        next_off <= {1'b0, rdata.off};
      end
    end
    if (cmd.decide) begin
      if (op == sflbf_pkg::ACT_POP) begin
        idx <= pos;
      end else begin
        idx <= count;
        if (!found) begin
          pos <= count;
        end
      end
    end
    if (cmd.up_wr) begin
      idx <= idx - 1'b1;
    end
    if (cmd.dn_wr) begin
      idx <= CW'(idx_inc);
    end
    if (cmd.set_st) begin
      res_st <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.put_new) begin
      count <= count + 1'b1;
    end else if (cmd.dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_st;
      if (res_st == sflbf_pkg::ST_POPPED) begin
        out_data <= {sflbf_pkg::CNT_W'(count), next_off, prev_off, hit.id, hit.size, hit.off};
      end else begin
        out_data <= {sflbf_pkg::CNT_W'(count), {(2 * sflbf_pkg::NB_W){1'b1}}, 95'd0};
      end
    end
  end

  assign sts.op_pop       = (op == sflbf_pkg::ACT_POP);
  assign sts.idx_eq_count = (idx == count);
  assign sts.idx_eq_pos   = (idx == pos);
  assign sts.dn_last      = (idx_inc >= {1'b0, count});
  assign sts.full         = (count == CW'(TABLE_DEPTH));
  assign sts.dup          = dup;
  assign sts.found        = found;
  assign sts.out_free     = !out_valid || out_ready;

endmodule

// File: hdl/sorted_free_list_best_fit.sv
// Top level of the best-fit free-region table.
//  channel | direction | tuser            | tdata
//  s_axis  | in        | action           | region_offset, region_size, region_id
//  m_axis  | out       | status           | found_*, prev/next_offset, entry_count
// An item passes through the accept, a scan that reads and checks each stored entry,
// the end of the scan, the decision and the result. An insert or pop that changes the
// table also shifts each entry behind the position with one read and one write.
// Reset empties the table; stored entries keep their contents.
// A result waits in the output register; a new word is taken while it waits.
`timescale 1ns / 1ps
module sorted_free_list_best_fit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // region_offset, region_size, region_id, zero pad
  input  logic         s_tuser,  // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [183:0] m_tdata,  // found_offset, found_size, found_id, prev_offset,
                                 // next_offset, entry_count
  output logic [2:0]   m_tuser   // status
);

  sflbf_pkg::cmd_t cmd;
  sflbf_pkg::sts_t sts;
  logic [$clog2(TABLE_DEPTH+1)-1:0] count;

  sflbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sflbf_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (s_tuser),
    .in_data    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_data   (m_tdata),
    .count      (count)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
    else $error("entry count above table depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("word accepted while busy");
  a_non_pop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sflbf_pkg::ST_POPPED |-> m_tdata[94:0] == 95'd0)
    else $error("found fields set on a non-pop result");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for the best-fit free-region table: random and directed words.
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic                         act;
    logic [sflbf_pkg::OFF_W-1:0]  off;
    logic [sflbf_pkg::SIZE_W-1:0] size;
    logic [sflbf_pkg::ID_W-1:0]   id;
  } req_t;

  typedef struct packed {
    logic [sflbf_pkg::ST_W-1:0]   st;
    logic [sflbf_pkg::OFF_W-1:0]  f_off;
    logic [sflbf_pkg::SIZE_W-1:0] f_size;
    logic [sflbf_pkg::ID_W-1:0]   f_id;
    logic [sflbf_pkg::NB_W-1:0]   prev;
    logic [sflbf_pkg::NB_W-1:0]   next;
    logic [sflbf_pkg::CNT_W-1:0]  cnt;
  } res_t;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [95:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [183:0] m_tdata;
  logic [2:0] m_tuser;

  sorted_free_list_best_fit #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  req_t pending_reqs[$];
  res_t expected_results[$];
  sflbf_pkg::entry_t free_table[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  bit pause_send = 0;
  bit in_taken = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic res_t predict_allocation(req_t r);
    res_t o;
    int pos;
    bit dup;
    o = '0;
    o.prev = '1;
    o.next = '1;
    if (r.act == sflbf_pkg::ACT_INSERT) begin
      dup = 0;
      foreach (free_table[i]) if (free_table[i].off == r.off) dup = 1;
      if (dup) o.st = sflbf_pkg::ST_DUP;
      else if (free_table.size() >= DEPTH) o.st = sflbf_pkg::ST_FULL;
      else begin
        pos = 0;
        while (pos < free_table.size() && free_table[pos].size <= r.size) pos++;
        free_table.insert(pos, '{off: r.off, size: r.size, id: r.id});
        o.st = sflbf_pkg::ST_INSERTED;
      end
    end else begin
      pos = 0;
      while (pos < free_table.size() && free_table[pos].size < r.size) pos++;
      if (pos >= free_table.size()) o.st = sflbf_pkg::ST_NOFIT;
      else begin
        o.f_off = free_table[pos].off;
        o.f_size = free_table[pos].size;
        o.f_id = free_table[pos].id;
        if (pos > 0) o.prev = {1'b0, free_table[pos-1].off};
        if (pos + 1 < free_table.size()) o.next = {1'b0, free_table[pos+1].off};
        free_table.delete(pos);
        o.st = sflbf_pkg::ST_POPPED;
      end
    end
    o.cnt = sflbf_pkg::CNT_W'(free_table.size());
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: inputs change at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_reqs.size() > 0 && !pause_send &&
          $urandom_range(99) >= send_idle_pct) begin
        req_t r;
        r = pending_reqs.pop_front();
        s_tvalid <= 1;
        s_tuser <= r.act;
        s_tdata <= {1'b0, r.id, r.size, r.off};
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Receiver: long hold-offs are counted here.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_tready <= 0;
      hold_off <= hold_off - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: samples on the rising edge.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req_t r;
        r.act = s_tuser;
        r.off = s_tdata[39:0];
        r.size = s_tdata[63:40];
        r.id = s_tdata[94:64];
        expected_results.push_back(predict_allocation(r));
      end
      if (m_tvalid && m_tready) begin
        res_t e;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", m_tuser, 0);
        end else begin
          e = expected_results.pop_front();
          if (m_tuser !== e.st) report_mismatch("status", m_tuser, e.st);
          if (m_tdata[39:0] !== e.f_off) report_mismatch("found_offset", m_tdata[39:0], e.f_off);
          if (m_tdata[63:40] !== e.f_size) report_mismatch("found_size", m_tdata[63:40], e.f_size);
          if (m_tdata[94:64] !== e.f_id) report_mismatch("found_id", m_tdata[94:64], e.f_id);
          if (m_tdata[135:95] !== e.prev) report_mismatch("prev_offset", m_tdata[135:95], e.prev);
          if (m_tdata[176:136] !== e.next) report_mismatch("next_offset", m_tdata[176:136], e.next);
          if (m_tdata[183:177] !== e.cnt) report_mismatch("entry_count", m_tdata[183:177], e.cnt);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic act, logic [39:0] off, logic [23:0] size,
                                    logic [30:0] id);
    req_t r;
    r.act = act;
    r.off = off;
    r.size = size;
    r.id = id;
    return r;
  endfunction

  function automatic logic [23:0] rand_size();
    case ($urandom_range(3))
      0: return 24'($urandom_range(15));
      1: return 24'($urandom_range(255));
      2: return 24'($urandom);
      default: return 24'hffffff - 24'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [39:0] rand_off();
    if ($urandom_range(3) == 0) return 40'($urandom_range(63));
    return 40'({$urandom, $urandom});
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55)
        pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, rand_off(), rand_size(),
                                        31'($urandom)));
      else
        pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, rand_off(), rand_size(),
                                        31'($urandom)));
    end
    wait_drained();
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tuser = 0;
    s_tdata = '0;
    m_tready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty pop, extremes, duplicates, equal sizes, zero request.
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 0, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 40'hff_ffff_ffff, 24'hffffff,
                                    31'h7fffffff));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 0, 0, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 0, 5, 9));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 10, 100, 1));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 20, 100, 2));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 30, 100, 3));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 40'hff_ffff_ffff, 100, 31'h7fffffff));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 0, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 24'hffffff, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 24'hffffff, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 101, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 1, 0));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, 1, 0));
    wait_drained();

    // Fill the table past full while the receiver holds off.
    hold_off = 400;
    for (int i = 0; i < DEPTH + 4; i++)
      pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 40'(1000 + i), rand_size(),
                                      31'(i)));
    pending_reqs.push_back(make_req(sflbf_pkg::ACT_INSERT, 1000, 7, 7));
    wait_drained();
    for (int i = 0; i < DEPTH / 2; i++)
      pending_reqs.push_back(make_req(sflbf_pkg::ACT_POP, 0, rand_size(), 0));
    wait_drained();

    random_phase(350, 0, 0);
    random_phase(350, 50, 0);
    random_phase(350, 0, 50);
    pause_send = 1;
    wait_drained();
    pause_send = 0;
    random_phase(350, 18, 18);

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: sorted_free_list_best_fit.f
hdl/sflbf_pkg.sv
hdl/sflbf_ctrl.sv
hdl/sflbf_dp.sv
hdl/sorted_free_list_best_fit.sv
bench/tb.sv
